// ----- hw/rtl/tsfc_pkg.sv -----
// shared types, constants and register indexes of the touch sample filter
package tsfc_pkg;

  // filter geometry
  localparam int SAMPLES_PER_AXIS = 5;
  localparam int TRIM_COUNT       = 1;
  localparam int TRIM_EFF = (2 * TRIM_COUNT >= SAMPLES_PER_AXIS) ?
                            (SAMPLES_PER_AXIS - 1) / 2 : TRIM_COUNT;
  localparam int KEEP     = SAMPLES_PER_AXIS - 2 * TRIM_EFF;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 16;
  localparam int SLOT_W   = $clog2(SAMPLES_PER_AXIS);
  localparam int SUM_W    = SAMPLE_W + $clog2(KEEP + 1);

  // mean by reciprocal multiply, exact floor for every sum below 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(KEEP);
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int RECIP_INT = ((1 << DIV_SHIFT) + KEEP - 1) / KEEP;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);

  // calibration arithmetic
  localparam int FRAC_W = 12;
  localparam int PROD_W = POS_W + SAMPLE_W + 1;
  localparam int CAL_W  = PROD_W + 1;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET  = 3'd6;

  // register reset values
  localparam logic [SAMPLE_W-1:0] ERR_RANGE_RST = 12'd50;
  localparam logic [POS_W-1:0]    GAIN_RST      = 16'd4096;
  localparam logic [POS_W-1:0]    POS_IDLE      = 16'hFFFF;

  // input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PEN_UP = 1'b1;

  // sample groups of one scan
  typedef enum logic [1:0] {
    GRP_A1 = 2'd0,
    GRP_B1 = 2'd1,
    GRP_A2 = 2'd2,
    GRP_B2 = 2'd3
  } group_t;

  // link between neighboring sort cells
  typedef struct packed {
    logic                gt;
    logic [SAMPLE_W-1:0] value;
  } link_t;

  // one result item
  typedef struct packed {
    logic             pressed;
    logic             just_released;
    logic             scan_ok;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;
  } result_t;

endpackage

// ----- hw/rtl/tsfc_if.sv -----
// valid/ready channel interfaces for samples and results
interface tsfc_in_if import tsfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface tsfc_out_if import tsfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pressed;
  logic             just_released;
  logic             scan_ok;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] start_x;
  logic [POS_W-1:0] start_y;

  modport source (output valid, output pressed, output just_released, output scan_ok,
                  output pos_x, output pos_y, output start_x, output start_y,
                  input ready);
  modport sink   (input valid, input pressed, input just_released, input scan_ok,
                  input pos_x, input pos_y, input start_x, input start_y,
                  output ready);
endinterface

// ----- hw/rtl/tsfc_sort_cell.sv -----
// one cell of the insertion sort row: holds a sample, shifts right on insert
module tsfc_sort_cell import tsfc_pkg::*; (
  input  logic                clk,
  input  logic                load,
  input  logic                occupied,
  input  logic [SAMPLE_W-1:0] x,
  input  link_t               left,
  output link_t               right
);

  logic [SAMPLE_W-1:0] value_r;
  logic [SAMPLE_W-1:0] value_nxt;
  logic                gt;

  // an empty cell counts as larger than any sample
  assign gt = !occupied || (x < value_r);

  // new sample lands at the first larger cell, larger ones move right
  always_comb begin
    value_nxt = value_r;
    if (load && gt) begin
      value_nxt = left.gt ? left.value : x;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign right.gt    = gt;
  assign right.value = value_r;

endmodule

// ----- hw/rtl/tsfc_out_fifo.sv -----
// result queue that parts the filter pipeline from the result channel
module tsfc_out_fifo import tsfc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  result_t          push_data,
  output logic [CNT_W-1:0] count,
  tsfc_out_if.source       out_ch
);

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;
  result_t          head;

  assign pop = out_ch.valid && out_ch.ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem[rd_ptr_r];
  assign count = count_r;

  // result channel
  assign out_ch.valid         = (count_r != '0);
  assign out_ch.pressed       = head.pressed;
  assign out_ch.just_released = head.just_released;
  assign out_ch.scan_ok       = head.scan_ok;
  assign out_ch.pos_x         = head.pos_x;
  assign out_ch.pos_y         = head.pos_y;
  assign out_ch.start_x       = head.start_x;
  assign out_ch.start_y       = head.start_y;

endmodule

// ----- hw/rtl/touch_sample_filter_calibrate_core.sv -----
// Touch sample filter: one input transfer per cycle. Samples enter a row of sort
// cells that keeps each group of samples in order as they arrive; the last sample
// of a group starts a six-stage pipeline (trimmed sum, mean by reciprocal
// multiply, pass check and average, gain multiply, offset and saturate with the
// press tracking); a result comes out for each pen-up tick and for the last
// group of each scan. Results wait in an 8-entry queue; the input is held off
// only while queued results plus items in flight would fill it.
module touch_sample_filter_calibrate_core import tsfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tsfc_in_if.sink               in_ch,
  tsfc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic                     raw_mode_r;
  logic                     swap_axes_r;
  logic [SAMPLE_W-1:0]      err_range_r;
  logic signed [POS_W-1:0]  x_gain_r;
  logic signed [POS_W-1:0]  x_offset_r;
  logic signed [POS_W-1:0]  y_gain_r;
  logic signed [POS_W-1:0]  y_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r  <= 1'b0;
      swap_axes_r <= 1'b0;
      err_range_r <= ERR_RANGE_RST;
      x_gain_r    <= GAIN_RST;
      x_offset_r  <= '0;
      y_gain_r    <= GAIN_RST;
      y_offset_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RAW_MODE:  raw_mode_r  <= cfg_data[0];
        CFG_SWAP_AXES: swap_axes_r <= cfg_data[0];
        CFG_ERR_RANGE: err_range_r <= cfg_data[SAMPLE_W-1:0];
        CFG_X_GAIN:    x_gain_r    <= cfg_data;
        CFG_X_OFFSET:  x_offset_r  <= cfg_data;
        CFG_Y_GAIN:    y_gain_r    <= cfg_data;
        CFG_Y_OFFSET:  y_offset_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // input transfer and credit against the result queue
  logic             in_xfer;
  logic             is_pen_up;
  logic [CNT_W-1:0] fifo_count;
  logic [2:0]       inflight;
  logic             t1_valid_r, t2_valid_r, t3_valid_r, t4_valid_r, t5_valid_r;

  assign inflight = 3'(t1_valid_r) + 3'(t2_valid_r) + 3'(t3_valid_r)
                  + 3'(t4_valid_r) + 3'(t5_valid_r);
  assign in_ch.ready = ((CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(inflight))
                       < (CNT_W + 1)'(FIFO_DEPTH);
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign is_pen_up = (in_ch.opcode == OP_PEN_UP);

  // slot and group counters
  logic [SLOT_W-1:0] slot_r;
  group_t            group_r;
  logic              group_end;

  assign group_end = (slot_r == SLOT_W'(SAMPLES_PER_AXIS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      group_r <= GRP_A1;
    end else if (in_xfer) begin
      if (is_pen_up) begin
        slot_r  <= '0;
        group_r <= GRP_A1;
      end else if (group_end) begin
        slot_r  <= '0;
        group_r <= group_t'(group_r + 2'd1);
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // row of sort cells
  link_t lnk [SAMPLES_PER_AXIS+1];
  logic  cell_load;

  assign lnk[0]    = '{gt: 1'b0, value: '0};
  assign cell_load = in_xfer && !is_pen_up;

  for (genvar i = 0; i < SAMPLES_PER_AXIS; i++) begin : g_cell
    tsfc_sort_cell u_cell (
      .clk      (clk),
      .load     (cell_load),
      .occupied (SLOT_W'(i) < slot_r),
      .x        (in_ch.sample),
      .left     (lnk[i]),
      .right    (lnk[i+1])
    );
  end

  // stage 1: a group is complete or a pen-up tick
  logic   t1_pen_up_r;
  group_t t1_group_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r <= 1'b0;
    end else begin
      t1_valid_r <= in_xfer && (is_pen_up || group_end);
    end
  end

  always_ff @(posedge clk) begin
    t1_pen_up_r <= is_pen_up;
    t1_group_r  <= group_r;
  end

  // stage 2: sum of the kept middle of the sorted row
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] t2_sum_r;
  logic             t2_pen_up_r;
  group_t           t2_group_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = TRIM_EFF; i < SAMPLES_PER_AXIS - TRIM_EFF; i++) begin
      sum_nxt = sum_nxt + SUM_W'(lnk[i+1].value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_valid_r <= 1'b0;
    end else begin
      t2_valid_r <= t1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    t2_sum_r    <= sum_nxt;
    t2_pen_up_r <= t1_pen_up_r;
    t2_group_r  <= t1_group_r;
  end

  // stage 3: truncating mean by reciprocal multiply
  logic [SUM_W+RECIP_W-1:0] mean_prod;
  logic [SAMPLE_W-1:0]      t3_mean_r;
  logic                     t3_pen_up_r;
  group_t                   t3_group_r;

  assign mean_prod = (SUM_W + RECIP_W)'(t2_sum_r) * (SUM_W + RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_valid_r <= 1'b0;
    end else begin
      t3_valid_r <= t2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    t3_mean_r   <= SAMPLE_W'(mean_prod >> DIV_SHIFT);
    t3_pen_up_r <= t2_pen_up_r;
    t3_group_r  <= t2_group_r;
  end

  // stage 4: pass bookkeeping, agreement check and pass average
  logic [SAMPLE_W-1:0] pass_a_mean_r;
  logic [SAMPLE_W-1:0] first_x_r, first_y_r;
  logic [SAMPLE_W-1:0] x2, y2, dx, dy;
  logic [SAMPLE_W:0]   sum_x, sum_y;
  logic                agree_ok;
  logic                scan_end;
  logic                t4_ok_r, t4_pen_up_r;
  logic [SAMPLE_W-1:0] t4_ax_r, t4_ay_r;

  assign scan_end = t3_valid_r && !t3_pen_up_r && (t3_group_r == GRP_B2);
  assign x2       = swap_axes_r ? t3_mean_r : pass_a_mean_r;
  assign y2       = swap_axes_r ? pass_a_mean_r : t3_mean_r;
  assign dx       = (first_x_r > x2) ? first_x_r - x2 : x2 - first_x_r;
  assign dy       = (first_y_r > y2) ? first_y_r - y2 : y2 - first_y_r;
  assign agree_ok = (dx < err_range_r) && (dy < err_range_r);
  assign sum_x    = (SAMPLE_W + 1)'(first_x_r) + (SAMPLE_W + 1)'(x2);
  assign sum_y    = (SAMPLE_W + 1)'(first_y_r) + (SAMPLE_W + 1)'(y2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_a_mean_r <= '0;
      first_x_r     <= '0;
      first_y_r     <= '0;
      t4_valid_r    <= 1'b0;
    end else begin
      t4_valid_r <= t3_valid_r && (t3_pen_up_r || (t3_group_r == GRP_B2));
      if (t3_valid_r && !t3_pen_up_r) begin
        case (t3_group_r)
          GRP_A1, GRP_A2: pass_a_mean_r <= t3_mean_r;
          GRP_B1: begin
            first_x_r <= x2;
            first_y_r <= y2;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    t4_ok_r     <= scan_end && agree_ok;
    t4_pen_up_r <= t3_pen_up_r;
    t4_ax_r     <= sum_x[SAMPLE_W:1];
    t4_ay_r     <= sum_y[SAMPLE_W:1];
  end

  // stage 5: gain multiply
  logic signed [PROD_W-1:0] gx_ext, gy_ext, ax_ext, ay_ext;
  logic signed [PROD_W-1:0] t5_px_r, t5_py_r;
  logic                     t5_ok_r, t5_pen_up_r;
  logic [SAMPLE_W-1:0]      t5_ax_r, t5_ay_r;

  assign gx_ext = PROD_W'(x_gain_r);
  assign gy_ext = PROD_W'(y_gain_r);
  assign ax_ext = $signed(PROD_W'(t4_ax_r));
  assign ay_ext = $signed(PROD_W'(t4_ay_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t5_valid_r <= 1'b0;
    end else begin
      t5_valid_r <= t4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    t5_px_r     <= gx_ext * ax_ext;
    t5_py_r     <= gy_ext * ay_ext;
    t5_ok_r     <= t4_ok_r;
    t5_pen_up_r <= t4_pen_up_r;
    t5_ax_r     <= t4_ax_r;
    t5_ay_r     <= t4_ay_r;
  end

  // stage 6: offset, clamp to the screen range
  logic signed [CAL_W-1:0] vx, vy;
  logic [POS_W-1:0]        cal_x, cal_y, new_x, new_y;

  assign vx = CAL_W'(t5_px_r) + $signed({x_offset_r[POS_W-1], x_offset_r, FRAC_W'(0)});
  assign vy = CAL_W'(t5_py_r) + $signed({y_offset_r[POS_W-1], y_offset_r, FRAC_W'(0)});

  always_comb begin
    if (vx[CAL_W-1]) begin
      cal_x = '0;
    end else if (vx[CAL_W-2]) begin
      cal_x = POS_IDLE;
    end else begin
      cal_x = vx[FRAC_W+POS_W-1:FRAC_W];
    end
    if (vy[CAL_W-1]) begin
      cal_y = '0;
    end else if (vy[CAL_W-2]) begin
      cal_y = POS_IDLE;
    end else begin
      cal_y = vy[FRAC_W+POS_W-1:FRAC_W];
    end
  end

  assign new_x = raw_mode_r ? POS_W'(t5_ax_r) : cal_x;
  assign new_y = raw_mode_r ? POS_W'(t5_ay_r) : cal_y;

  // position and press tracking
  logic [POS_W-1:0] pos_x_r, pos_y_r, start_x_r, start_y_r;
  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt, start_x_nxt, start_y_nxt;
  logic             down_r, down_nxt, released;
  result_t          res;

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    down_nxt    = down_r;
    released    = 1'b0;
    if (t5_pen_up_r) begin
      if (down_r) begin
        down_nxt = 1'b0;
        released = 1'b1;
      end else begin
        start_x_nxt = '0;
        start_y_nxt = '0;
        pos_x_nxt   = POS_IDLE;
        pos_y_nxt   = POS_IDLE;
      end
    end else begin
      if (t5_ok_r) begin
        pos_x_nxt = new_x;
        pos_y_nxt = new_y;
      end
      if (!down_r) begin
        down_nxt    = 1'b1;
        start_x_nxt = pos_x_nxt;
        start_y_nxt = pos_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      down_r    <= 1'b0;
    end else if (t5_valid_r) begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      down_r    <= down_nxt;
    end
  end

  assign res.pressed       = down_nxt;
  assign res.just_released = released;
  assign res.scan_ok       = t5_ok_r && !t5_pen_up_r;
  assign res.pos_x         = pos_x_nxt;
  assign res.pos_y         = pos_y_nxt;
  assign res.start_x       = start_x_nxt;
  assign res.start_y       = start_y_nxt;

  // result queue
  tsfc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (t5_valid_r),
    .push_data (res),
    .count     (fifo_count),
    .out_ch    (out_ch)
  );

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the touch sample filter core
module testbench import tsfc_pkg::*;;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;
  localparam int SCAN_LEN      = 4 * SAMPLES_PER_AXIS;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsfc_in_if  in_ch ();
  tsfc_out_if out_ch ();

  touch_sample_filter_calibrate_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // register copies
  logic                cfg_raw  = 1'b0;
  logic                cfg_swap = 1'b0;
  logic [SAMPLE_W-1:0] cfg_err  = ERR_RANGE_RST;
  logic [POS_W-1:0]    cfg_xg   = GAIN_RST;
  logic [POS_W-1:0]    cfg_xo   = '0;
  logic [POS_W-1:0]    cfg_yg   = GAIN_RST;
  logic [POS_W-1:0]    cfg_yo   = '0;

  // filter state
  logic [SAMPLE_W-1:0] grp_buf [SAMPLES_PER_AXIS];
  int                  grp_fill        = 0;
  logic [SAMPLE_W-1:0] first_axis_mean = '0;
  logic [SAMPLE_W-1:0] pass1_x         = '0;
  logic [SAMPLE_W-1:0] pass1_y         = '0;
  logic [POS_W-1:0]    cur_x           = '0;
  logic [POS_W-1:0]    cur_y           = '0;
  logic [POS_W-1:0]    touch_x         = '0;
  logic [POS_W-1:0]    touch_y         = '0;
  logic                pen_down        = 1'b0;

  result_t report_fifo [$];

  int  n_xfers     = 0;
  int  n_results   = 0;
  int  n_scan_ok   = 0;
  int  n_releases  = 0;
  int  n_errors    = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  idle_en     = 1'b1;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // sort one group and average what is left after trimming
  function automatic logic [SAMPLE_W-1:0] trimmed_mean();
    logic [SAMPLE_W-1:0] srt [SAMPLES_PER_AXIS];
    logic [SAMPLE_W-1:0] t;
    int j, trim, total;
    srt = grp_buf;
    for (int i = 1; i < SAMPLES_PER_AXIS; i++) begin
      t = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > t) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = t;
    end
    trim = TRIM_COUNT;
    if (2 * trim >= SAMPLES_PER_AXIS) trim = (SAMPLES_PER_AXIS - 1) / 2;
    total = 0;
    for (int i = trim; i < SAMPLES_PER_AXIS - trim; i++) total += srt[i];
    return SAMPLE_W'(total / (SAMPLES_PER_AXIS - 2 * trim));
  endfunction

  // gain and offset to pixels, clamped to 0..65535
  function automatic logic [POS_W-1:0] to_pixels(input logic [SAMPLE_W-1:0] raw,
                                                 input logic [POS_W-1:0] gain,
                                                 input logic [POS_W-1:0] offs);
    longint v;
    v = longint'($signed(gain)) * longint'(raw) + longint'($signed(offs)) * 4096;
    if (v < 0) return '0;
    v = v / 4096;
    return (v > 65535) ? POS_IDLE : POS_W'(v);
  endfunction

  function automatic bit within_window(input logic [SAMPLE_W-1:0] a,
                                       input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d < cfg_err;
  endfunction

  // one accepted item through the filter; 1 when it yields a report
  function automatic bit filter_touch(input logic op, input logic [SAMPLE_W-1:0] smp,
                                      output result_t rep);
    group_t              grp;
    int                  slot;
    logic [SAMPLE_W-1:0] m, x2, y2, ax, ay;
    bit                  released, ok;
    released = 1'b0;
    ok       = 1'b0;
    rep      = '0;
    if (op == OP_PEN_UP) begin
      grp_fill = 0;
      if (pen_down) begin
        pen_down = 1'b0;
        released = 1'b1;
      end else begin
        touch_x = '0;
        touch_y = '0;
        cur_x   = POS_IDLE;
        cur_y   = POS_IDLE;
      end
    end else begin
      if (grp_fill >= SCAN_LEN) grp_fill = 0;
      grp  = group_t'(grp_fill / SAMPLES_PER_AXIS);
      slot = grp_fill % SAMPLES_PER_AXIS;
      grp_buf[slot] = smp;
      grp_fill++;
      if (slot != SAMPLES_PER_AXIS - 1) return 1'b0;
      m = trimmed_mean();
      case (grp)
        GRP_A1, GRP_A2: begin
          first_axis_mean = m;
          return 1'b0;
        end
        GRP_B1: begin
          pass1_x = cfg_swap ? m : first_axis_mean;
          pass1_y = cfg_swap ? first_axis_mean : m;
          return 1'b0;
        end
        default: begin
          x2 = cfg_swap ? m : first_axis_mean;
          y2 = cfg_swap ? first_axis_mean : m;
          grp_fill = 0;
          if (within_window(pass1_x, x2) && within_window(pass1_y, y2)) begin
            ax = SAMPLE_W'((int'(pass1_x) + int'(x2)) / 2);
            ay = SAMPLE_W'((int'(pass1_y) + int'(y2)) / 2);
            ok = 1'b1;
            if (cfg_raw) begin
              cur_x = POS_W'(ax);
              cur_y = POS_W'(ay);
            end else begin
              cur_x = to_pixels(ax, cfg_xg, cfg_xo);
              cur_y = to_pixels(ay, cfg_yg, cfg_yo);
            end
          end
          if (!pen_down) begin
            pen_down = 1'b1;
            touch_x  = cur_x;
            touch_y  = cur_y;
          end
        end
      endcase
    end
    rep.pressed       = pen_down;
    rep.just_released = released;
    rep.scan_ok       = ok;
    rep.pos_x         = cur_x;
    rep.pos_y         = cur_y;
    rep.start_x       = touch_x;
    rep.start_y       = touch_y;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    n_errors++;
    if (n_errors <= REPORT_LIMIT) begin
      $display("%0t %s: exp p%0b r%0b ok%0b pos %0d,%0d start %0d,%0d",
               $realtime, what,
               want.pressed, want.just_released, want.scan_ok, want.pos_x, want.pos_y,
               want.start_x, want.start_y);
      $display("    got p%0b r%0b ok%0b pos %0d,%0d start %0d,%0d",
               got.pressed, got.just_released, got.scan_ok, got.pos_x, got.pos_y,
               got.start_x, got.start_y);
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pressed       = out_ch.pressed;
      got.just_released = out_ch.just_released;
      got.scan_ok       = out_ch.scan_ok;
      got.pos_x         = out_ch.pos_x;
      got.pos_y         = out_ch.pos_y;
      got.start_x       = out_ch.start_x;
      got.start_y       = out_ch.start_y;
      if (report_fifo.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = report_fifo.pop_front();
        n_results++;
        if (want.scan_ok) n_scan_ok++;
        if (want.just_released) n_releases++;
        if (got !== want) note_mismatch("mismatch", want, got);
      end
    end
  end

  // send one item; returns at the falling edge after its transfer
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] smp);
    result_t rep;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    n_xfers++;
    if (filter_touch(op, smp, rep)) report_fifo.push_back(rep);
    @(negedge clk);
  endtask

  // stop sending and let every queued result drain
  task automatic settle();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (report_fifo.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_RAW_MODE:  cfg_raw  = data[0];
      CFG_SWAP_AXES: cfg_swap = data[0];
      CFG_ERR_RANGE: cfg_err  = data[SAMPLE_W-1:0];
      CFG_X_GAIN:    cfg_xg   = data;
      CFG_X_OFFSET:  cfg_xo   = data;
      CFG_Y_GAIN:    cfg_yg   = data;
      CFG_Y_OFFSET:  cfg_yo   = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // write all registers; unused high bits carry random junk
  task automatic load_settings(input logic raw, input logic swap,
                               input logic [SAMPLE_W-1:0] err,
                               input logic [POS_W-1:0] xg, input logic [POS_W-1:0] xo,
                               input logic [POS_W-1:0] yg, input logic [POS_W-1:0] yo,
                               input bit poke_unused);
    settle();
    put_reg(CFG_RAW_MODE,  {15'($urandom), raw});
    put_reg(CFG_SWAP_AXES, {15'($urandom), swap});
    put_reg(CFG_ERR_RANGE, {4'($urandom), err});
    put_reg(CFG_X_GAIN,    xg);
    put_reg(CFG_X_OFFSET,  xo);
    put_reg(CFG_Y_GAIN,    yg);
    put_reg(CFG_Y_OFFSET,  yo);
    if (poke_unused) put_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] clip12(input int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return SAMPLE_W'(v);
  endfunction

  function automatic int pick_base();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int pick_jitter();
    case ($urandom_range(0, 4))
      0, 1: return 0;
      2: return 2;
      3: return 40;
      default: return 4095;
    endcase
  endfunction

  // pass-to-pass shift, often right at the window edge
  function automatic int pick_shift();
    int mag;
    case ($urandom_range(0, 4))
      0: mag = 0;
      1: mag = int'(cfg_err) - 1;
      2: mag = int'(cfg_err);
      3: mag = int'(cfg_err) + 1;
      default: mag = int'($urandom_range(0, 4095));
    endcase
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // one well-formed scan in the order the current axis setting expects
  task automatic send_scan(input int bx, input int by, input int jit,
                           input int dx, input int dy);
    bit on_y;
    int base;
    for (int p = 0; p < 2; p++) begin
      for (int a = 0; a < 2; a++) begin
        on_y = (a == 0) ? cfg_swap : !cfg_swap;
        base = on_y ? by + p * dy : bx + p * dx;
        for (int s = 0; s < SAMPLES_PER_AXIS; s++)
          send_item(OP_SAMPLE, clip12(base + int'($urandom_range(0, 2 * jit)) - jit));
      end
    end
  endtask

  // mostly presses made of full scans, some stray ticks and broken scans
  task automatic run_touches(input int n);
    int start, k;
    start = n_xfers;
    while (n_xfers - start < n) begin
      case ($urandom_range(0, 9))
        0: send_item(OP_PEN_UP, SAMPLE_W'($urandom));
        1: begin
          k = $urandom_range(1, SCAN_LEN - 1);
          repeat (k) send_item(OP_SAMPLE, SAMPLE_W'($urandom));
          if ($urandom_range(0, 1)) send_item(OP_PEN_UP, SAMPLE_W'($urandom));
        end
        default: begin
          send_scan(pick_base(), pick_base(), pick_jitter(), pick_shift(), pick_shift());
          if ($urandom_range(0, 2) == 0) send_item(OP_PEN_UP, SAMPLE_W'($urandom));
        end
      endcase
    end
  endtask

  // idle tick, a scan with extreme samples, release, stray tick, pen-up mid scan
  task automatic test_directed();
    logic [SAMPLE_W-1:0] scan [SCAN_LEN] = '{
      12'd0,    12'd4095, 12'd4095, 12'd0,    12'd2048,
      12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
      12'd2048, 12'd2047, 12'd2046, 12'd0,    12'd4095,
      12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095};
    send_item(OP_PEN_UP, 12'hFFF);
    foreach (scan[i]) send_item(OP_SAMPLE, scan[i]);
    send_item(OP_PEN_UP, 12'h000);
    send_item(OP_PEN_UP, 12'hA5A);
    send_item(OP_SAMPLE, 12'h555);
    send_item(OP_SAMPLE, 12'hAAA);
    send_item(OP_SAMPLE, 12'hFFF);
    send_item(OP_PEN_UP, 12'h5A5);
  endtask

  // raw coordinates with a window so wide that only a pass-to-pass difference of 4095 fails
  task automatic test_raw_mode();
    load_settings(1'b1, 1'b0, 12'd4095, GAIN_RST, 16'h0000, GAIN_RST, 16'h0000, 1'b0);
    run_touches(48);
  endtask

  // swapped axis order with a zero window, so no scan can pass
  task automatic test_swap_zero_window();
    load_settings(1'b0, 1'b1, 12'd0, GAIN_RST, 16'h0000, GAIN_RST, 16'h0000, 1'b0);
    run_touches(48);
  endtask

  // gain and offset extremes: top saturation, clamp at zero, mixed signs
  task automatic test_gain_extremes();
    load_settings(1'b0, 1'b0, 12'd200, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    run_touches(48);
    load_settings(1'b0, 1'b1, 12'd200, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    run_touches(48);
    load_settings(1'b0, 1'b0, 12'd300, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    run_touches(48);
  endtask

  // random register values, error range within 0..600, with a write to the unused index
  task automatic test_random_settings();
    repeat (2) begin
      load_settings(1'($urandom), 1'($urandom), 12'($urandom_range(0, 600)),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
      run_touches(48);
    end
  endtask

  // reset values back, no gaps on either side
  task automatic test_back_to_back();
    load_settings(1'b0, 1'b0, ERR_RANGE_RST, GAIN_RST, 16'h0000, GAIN_RST, 16'h0000, 1'b0);
    idle_en = 1'b0;
    run_touches(80);
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_SAMPLE;
    in_ch.sample <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_raw_mode();
    test_swap_zero_window();
    test_gain_extremes();
    test_random_settings();
    test_back_to_back();

    settle();
    if (report_fifo.size() != 0) begin
      $display("%0d results never arrived", report_fifo.size());
      n_errors += report_fifo.size();
    end
    $display("run covered %0d input transfers and %0d checked results over 8 settings",
             n_xfers, n_results);
    $display("%0d scans passed the pass check, %0d releases seen", n_scan_ok, n_releases);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- touch_sample_filter_calibrate_core.f -----
hw/rtl/tsfc_pkg.sv
hw/rtl/tsfc_if.sv
hw/rtl/tsfc_sort_cell.sv
hw/rtl/tsfc_out_fifo.sv
hw/rtl/touch_sample_filter_calibrate_core.sv
bench/testbench.sv
